// ===== rtl/core/gdil_pkg.sv =====
// Shared types and constants of the grid obstacle dilation unit.
// Used by gdil_in_if, gdil_cfg_if and the top level; depends on nothing.
`default_nettype none

package gdil_pkg;

  // Grid capacity.
  localparam int MAX_ROWS = 32;
  localparam int MAX_COLS = 64;
  localparam int ROW_AW   = $clog2(MAX_ROWS);
  localparam int COL_AW   = $clog2(MAX_COLS);

  // Request fields.
  localparam int ROW_W = 5;
  localparam int COL_W = 6;

  // Configuration registers.
  localparam int PASSES_W = 4;
  localparam int ROWS_W   = 6;
  localparam int COLS_W   = 7;
  localparam int CFG_IW   = 2;
  localparam int CFG_DW   = 7;

  localparam logic [CFG_IW-1:0] CFG_PASSES = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_ROWS   = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_COLS   = 2'd2;

  localparam logic [PASSES_W-1:0] PASSES_RST = 4'd1;
  localparam logic [ROWS_W-1:0]   ROWS_RST   = 6'd30;
  localparam logic [COLS_W-1:0]   COLS_RST   = 7'd40;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_RUN  = 2'd1,
    OP_READ = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

endpackage

`default_nettype wire

// ===== rtl/core/gdil_in_if.sv =====
// Request channel of the grid obstacle dilation unit.
// Depends on gdil_pkg.
`default_nettype none

interface gdil_in_if;
  logic                      valid;
  logic                      ready;
  gdil_pkg::op_t             op;
  logic [gdil_pkg::ROW_W-1:0] row;
  logic [gdil_pkg::COL_W-1:0] col;
  logic                      cell_value;

  modport source (output valid, op, row, col, cell_value, input ready);
  modport sink   (input valid, op, row, col, cell_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/gdil_out_if.sv =====
// Result channel of the grid obstacle dilation unit.
// Self-contained; no package items are needed.
`default_nettype none

interface gdil_out_if;
  logic valid;
  logic ready;
  logic cell_out;
  logic is_done;

  modport source (output valid, cell_out, is_done, input ready);
  modport sink   (input valid, cell_out, is_done, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/gdil_cfg_if.sv =====
// Configuration write channel of the grid obstacle dilation unit.
// Depends on gdil_pkg.
`default_nettype none

interface gdil_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [gdil_pkg::CFG_IW-1:0] index;
  logic [gdil_pkg::CFG_DW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/grid_obstacle_dilation_unit.sv =====
// Top level of the grid obstacle dilation unit: two row-wide grid banks and
// a row sequencer that applies 3x3 dilation passes. Depends on gdil_pkg,
// gdil_in_if, gdil_out_if and gdil_cfg_if.
//
//   channel   direction  carries
//   in_chan   sink       op, row, col, cell_value
//   out_chan  source     cell_out, is_done
//   cfg_chan  sink       index, data (passes, rows_in_use, cols_in_use)
//
// A load writes its cell when taken; a read registers the row, then selects the bit.
// A run with zero passes or an empty area goes straight to its done answer;
// otherwise each pass primes a three-row window in S_PRIME and S_FIRST and then
// writes one new row per cycle through the single bank read port.
// Reset is synchronous and clears control state only; the grid is undefined
// until loaded. A stalled result holds the block in its final state.
`default_nettype none

module grid_obstacle_dilation_unit (
  input  wire        clk,
  input  wire        rst_n,
  gdil_in_if.sink    in_chan,
  gdil_out_if.source out_chan,
  gdil_cfg_if.sink   cfg_chan
);

  localparam int ROWS = gdil_pkg::MAX_ROWS;
  localparam int COLS = gdil_pkg::MAX_COLS;
  localparam int RAW  = gdil_pkg::ROW_AW;
  localparam int CAW  = gdil_pkg::COL_AW;
  localparam int PW   = gdil_pkg::PASSES_W;
  localparam int RW   = gdil_pkg::ROWS_W;
  localparam int CW   = gdil_pkg::COLS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CELL,
    S_PRIME,
    S_FIRST,
    S_ROW,
    S_DONE
  } state_t;

  state_t state_r;

  // Configuration.
  logic [PW-1:0] passes_r;
  logic [RW-1:0] rows_r;
  logic [CW-1:0] cols_r;

  // Sequencer.
  logic           sel_r;
  logic [RAW-1:0] r_r;
  logic [PW-1:0]  pass_r;
  logic [COLS-1:0] prev_r;
  logic [COLS-1:0] cur_r;
  logic [CAW-1:0] col_r;
  logic           inside_r;

  // Output register.
  logic out_valid_r;
  logic cell_out_r;
  logic is_done_r;

  // Grid banks; sel_r names the bank that holds the current grid.
  logic [COLS-1:0] bank0 [ROWS];
  logic [COLS-1:0] bank1 [ROWS];
  logic [COLS-1:0] rdata0_r;
  logic [COLS-1:0] rdata1_r;

  logic           in_acc;
  logic           out_free;
  logic           in_inside;
  logic           ld_we;
  logic           row_we;
  logic           rd_en;
  logic [RAW-1:0] rd_addr;
  logic [RAW-1:0] ld_row;
  logic [CAW-1:0] ld_col;
  logic [COLS-1:0] rdata;
  logic [COLS-1:0] nxt_row;
  logic [COLS-1:0] neigh;
  logic [COLS-1:0] new_row;
  logic [RW-1:0]  nr_eff;
  logic [CW-1:0]  nc_eff;
  logic           last_row;
  logic           row_in_area;
  logic           row_border;
  logic [PW-1:0]  pass_nxt;
  logic           skip_run;

  assign in_chan.ready  = (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign out_chan.valid    = out_valid_r;
  assign out_chan.cell_out = cell_out_r;
  assign out_chan.is_done  = is_done_r;

  assign in_acc   = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;

  assign in_inside = (int'(in_chan.row) < ROWS) && (int'(in_chan.col) < COLS);
  assign ld_row    = RAW'(in_chan.row);
  assign ld_col    = CAW'(in_chan.col);
  assign ld_we     = in_acc && (in_chan.op == gdil_pkg::OP_LOAD) && in_inside;
  assign row_we    = (state_r == S_ROW);

  assign nr_eff = (int'(rows_r) > ROWS) ? RW'(ROWS) : rows_r;
  assign nc_eff = (int'(cols_r) > COLS) ? CW'(COLS) : cols_r;
  assign skip_run = (nr_eff == '0) || (nc_eff == '0) || (passes_r == '0);

  assign rdata    = sel_r ? rdata1_r : rdata0_r;
  assign last_row = (r_r == RAW'(ROWS - 1));
  assign nxt_row  = last_row ? '0 : rdata;
  assign pass_nxt = pass_r + PW'(1);

  // Read port control.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ld_row;
    case (state_r)
      S_IDLE: begin
        rd_en = in_acc && (in_chan.op == gdil_pkg::OP_READ);
      end
      S_PRIME: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      S_FIRST: begin
        rd_en   = 1'b1;
        rd_addr = RAW'(1);
      end
      S_ROW: begin
        rd_en   = !last_row;
        rd_addr = r_r + RAW'(2);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Row dilation: the whole row of the window is handled at once, one row
  // per cycle. Neighbors matter only for interior cells, so bits shifted in
  // at the row ends are never used.
  assign neigh = prev_r | (prev_r << 1) | (prev_r >> 1) |
                 (cur_r << 1) | (cur_r >> 1) |
                 nxt_row | (nxt_row << 1) | (nxt_row >> 1);

  assign row_in_area = (RW'(r_r) < nr_eff);
  assign row_border  = (r_r == '0) || (RW'(r_r) == nr_eff - RW'(1));

  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      if (row_in_area && (CW'(c) < nc_eff)) begin
        new_row[c] = cur_r[c] | row_border | (c == 0) ||
                     (CW'(c) == nc_eff - CW'(1)) || neigh[c];
      end else begin
        new_row[c] = cur_r[c];
      end
    end
  end

  // Bank memories: row writes go to the bank being built, loads and all
  // reads outside a run to the current bank.
  always_ff @(posedge clk) begin
    if (row_we && !sel_r) begin
      bank1[r_r] <= new_row;
    end else if (ld_we && sel_r) begin
      bank1[ld_row][ld_col] <= in_chan.cell_value;
    end
  end

  always_ff @(posedge clk) begin
    if (row_we && sel_r) begin
      bank0[r_r] <= new_row;
    end else if (ld_we && !sel_r) begin
      bank0[ld_row][ld_col] <= in_chan.cell_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata0_r <= bank0[rd_addr];
      rdata1_r <= bank1[rd_addr];
    end
  end

  // Sequencer, configuration and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= 1'b0;
      pass_r      <= '0;
      r_r         <= '0;
      out_valid_r <= 1'b0;
      passes_r    <= gdil_pkg::PASSES_RST;
      rows_r      <= gdil_pkg::ROWS_RST;
      cols_r      <= gdil_pkg::COLS_RST;
    end else begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        case (cfg_chan.index)
          gdil_pkg::CFG_PASSES: passes_r <= PW'(cfg_chan.data);
          gdil_pkg::CFG_ROWS:   rows_r   <= RW'(cfg_chan.data);
          gdil_pkg::CFG_COLS:   cols_r   <= CW'(cfg_chan.data);
          default: ;
        endcase
      end

      // The result states load the output register themselves.
      if (out_chan.ready && (state_r != S_CELL) && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            case (in_chan.op)
              gdil_pkg::OP_RUN: begin
                pass_r  <= '0;
                state_r <= skip_run ? S_DONE : S_PRIME;
              end
              gdil_pkg::OP_READ: begin
                col_r    <= ld_col;
                inside_r <= in_inside;
                state_r  <= S_CELL;
              end
              default: ;
            endcase
          end
        end
        S_CELL: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            cell_out_r  <= inside_r && rdata[col_r];
            is_done_r   <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        S_PRIME: begin
          state_r <= S_FIRST;
        end
        S_FIRST: begin
          prev_r  <= '0;
          cur_r   <= rdata;
          r_r     <= '0;
          state_r <= S_ROW;
        end
        S_ROW: begin
          prev_r <= cur_r;
          cur_r  <= nxt_row;
          if (last_row) begin
            sel_r  <= !sel_r;
            pass_r <= pass_nxt;
            state_r <= (pass_nxt == passes_r) ? S_DONE : S_PRIME;
          end else begin
            r_r <= r_r + RAW'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            cell_out_r  <= 1'b0;
            is_done_r   <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== verif/gdil_grid_checker.sv =====
// Checker of the grid obstacle dilation unit: keeps its own grid and register copy,
// predicts every read and run answer, and compares the answers it sees.
// Depends on gdil_pkg, gdil_in_if, gdil_out_if and gdil_cfg_if.
module gdil_grid_checker (
  input  logic clk,
  input  logic rst_n,
  gdil_in_if   in_ch,
  gdil_out_if  out_ch,
  gdil_cfg_if  cfg_ch,
  output int   pending_results,
  output int   mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                       cell_out;
    logic                       is_done;
    logic [gdil_pkg::ROW_W-1:0] row;
    logic [gdil_pkg::COL_W-1:0] col;
  } cell_answer_t;

  bit                            occupancy_model [gdil_pkg::MAX_ROWS][gdil_pkg::MAX_COLS];
  logic [gdil_pkg::PASSES_W-1:0] pass_count;
  logic [gdil_pkg::ROWS_W-1:0]   row_limit;
  logic [gdil_pkg::COLS_W-1:0]   col_limit;
  cell_answer_t                  awaited_answers [$];

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // Applies the configured number of 3x3 dilation passes to the area in use.
  function automatic void dilate_grid();
    bit next_grid [gdil_pkg::MAX_ROWS][gdil_pkg::MAX_COLS];
    int nr;
    int nc;
    bit grow;
    nr = (row_limit > gdil_pkg::MAX_ROWS) ? gdil_pkg::MAX_ROWS : int'(row_limit);
    nc = (col_limit > gdil_pkg::MAX_COLS) ? gdil_pkg::MAX_COLS : int'(col_limit);
    if (nr == 0 || nc == 0) return;
    for (int p = 0; p < int'(pass_count); p++) begin
      next_grid = occupancy_model;
      for (int r = 0; r < nr; r++) begin
        for (int c = 0; c < nc; c++) begin
          if (!occupancy_model[r][c]) begin
            grow = (r == 0 || c == 0 || r == nr - 1 || c == nc - 1);
            // Border cells are settled above, so the neighbors below lie inside.
            for (int dr = -1; dr <= 1; dr++) begin
              for (int dc = -1; dc <= 1; dc++) begin
                if (!grow && occupancy_model[r + dr][c + dc]) grow = 1'b1;
              end
            end
            if (grow) next_grid[r][c] = 1'b1;
          end
        end
      end
      occupancy_model = next_grid;
    end
  endfunction

  always @(posedge clk) begin
    cell_answer_t want;
    cell_answer_t fresh;
    if (!rst_n) begin
      pass_count = gdil_pkg::PASSES_RST;
      row_limit  = gdil_pkg::ROWS_RST;
      col_limit  = gdil_pkg::COLS_RST;
      awaited_answers.delete();
    end else begin
      // The result side goes first: an answer never belongs to a request taken
      // at the same edge.
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_answers.size() == 0) begin
          report_mismatch($sformatf("answer with nothing awaited: cell_out=%0b is_done=%0b",
                                    out_ch.cell_out, out_ch.is_done));
        end else begin
          want = awaited_answers.pop_front();
          if (out_ch.is_done !== want.is_done) begin
            report_mismatch($sformatf("is_done=%0b, expected %0b (cell %0d,%0d)",
                                      out_ch.is_done, want.is_done, want.row, want.col));
          end
          if (out_ch.cell_out !== want.cell_out) begin
            report_mismatch($sformatf("cell_out=%0b, expected %0b (is_done %0b, cell %0d,%0d)",
                                      out_ch.cell_out, want.cell_out, want.is_done,
                                      want.row, want.col));
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          gdil_pkg::CFG_PASSES: pass_count = cfg_ch.data[gdil_pkg::PASSES_W-1:0];
          gdil_pkg::CFG_ROWS:   row_limit  = cfg_ch.data[gdil_pkg::ROWS_W-1:0];
          gdil_pkg::CFG_COLS:   col_limit  = cfg_ch.data[gdil_pkg::COLS_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        fresh.row = in_ch.row;
        fresh.col = in_ch.col;
        // Row and column fields cannot address a cell beyond the grid.
        case (in_ch.op)
          gdil_pkg::OP_LOAD: occupancy_model[in_ch.row][in_ch.col] = in_ch.cell_value;
          gdil_pkg::OP_RUN: begin
            dilate_grid();
            fresh.cell_out = 1'b0;
            fresh.is_done  = 1'b1;
            awaited_answers = {awaited_answers, fresh};
          end
          gdil_pkg::OP_READ: begin
            fresh.cell_out = occupancy_model[in_ch.row][in_ch.col];
            fresh.is_done  = 1'b0;
            awaited_answers = {awaited_answers, fresh};
          end
          default: ;
        endcase
      end
    end
    pending_results = awaited_answers.size();
  end

endmodule

// ===== verif/grid_obstacle_dilation_unit_tb.sv =====
// Testbench top of the grid obstacle dilation unit: drives requests and register
// writes, paces the result side and prints the verdict.
// Depends on gdil_pkg, the three channel interfaces, gdil_grid_checker and the block.
module grid_obstacle_dilation_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET    = 1550;
  localparam int CALM_AFTER     = 1320;
  localparam int BACKLOG_CYCLES = 400;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 16;
  localparam int TIMEOUT_CYCLES = 500_000;
  localparam int AREA_CAP       = 384;
  localparam int FIXED_PHASES   = 6;
  localparam logic [gdil_pkg::CFG_IW-1:0] CFG_SPARE = 2'd3;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic calm  = 1'b0;
  logic backlog_req = 1'b0;

  int pending_results;
  int mismatch_count;
  int requests_sent = 0;
  int area_rows = gdil_pkg::ROWS_RST;
  int area_cols = gdil_pkg::COLS_RST;
  bit loaded [gdil_pkg::MAX_ROWS][gdil_pkg::MAX_COLS];

  // Early phases cover zero passes, the largest pass count, saturated sizes,
  // a single bordered row and empty areas.
  int fixed_passes [FIXED_PHASES] = '{0, 15, 2, 3, 4, 1};
  int fixed_rows   [FIXED_PHASES] = '{3, 63, 1, 0, 5, 4};
  int fixed_cols   [FIXED_PHASES] = '{3, 2, 127, 10, 64, 0};

  gdil_in_if  in_ch ();
  gdil_out_if out_ch ();
  gdil_cfg_if cfg_ch ();

  grid_obstacle_dilation_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch),
    .cfg_chan (cfg_ch)
  );

  gdil_grid_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .cfg_ch          (cfg_ch),
    .pending_results (pending_results),
    .mismatch_count  (mismatch_count)
  );

  always #6 clk = ~clk;

  task automatic send_request(input gdil_pkg::op_t op, input int r, input int c,
                              input logic v);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.row        <= r[gdil_pkg::ROW_W-1:0];
    in_ch.col        <= c[gdil_pkg::COL_W-1:0];
    in_ch.cell_value <= v;
    do @(posedge clk); while (!in_ch.ready);
    if (op == gdil_pkg::OP_LOAD) loaded[r][c] = 1'b1;
    if (op != gdil_pkg::OP_NOP) requests_sent++;
    if (requests_sent >= CALM_AFTER) calm <= 1'b1;
  endtask

  // Stops offering requests and waits until every awaited answer is back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_results != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic settle();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [gdil_pkg::CFG_IW-1:0] idx, input int value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value[gdil_pkg::CFG_DW-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    case (idx)
      gdil_pkg::CFG_ROWS: area_rows = (value > gdil_pkg::MAX_ROWS) ? gdil_pkg::MAX_ROWS : value;
      gdil_pkg::CFG_COLS: area_cols = (value > gdil_pkg::MAX_COLS) ? gdil_pkg::MAX_COLS : value;
      default: ;
    endcase
  endtask

  task automatic configure(input int p, input int rw, input int cl);
    settle();
    if ($urandom_range(0, 5) == 0) write_reg(CFG_SPARE, $urandom_range(0, 127));
    write_reg(gdil_pkg::CFG_PASSES, p);
    write_reg(gdil_pkg::CFG_ROWS, rw);
    write_reg(gdil_pkg::CFG_COLS, cl);
  endtask

  task automatic pick_config(output int p, output int rw, output int cl);
    int eff_rows;
    int eff_cols;
    case ($urandom_range(0, 7))
      0:       p = 0;
      1:       p = 15;
      default: p = $urandom_range(1, 4);
    endcase
    case ($urandom_range(0, 9))
      0:       rw = 0;
      1:       rw = 32;
      2:       rw = 63;
      3:       rw = 1;
      4:       rw = $urandom_range(9, 31);
      default: rw = $urandom_range(2, 8);
    endcase
    case ($urandom_range(0, 9))
      0:       cl = 0;
      1:       cl = 64;
      2:       cl = 127;
      3:       cl = 1;
      4:       cl = $urandom_range(13, 40);
      default: cl = $urandom_range(2, 12);
    endcase
    // Keep the area small so that loading it stays cheap.
    eff_rows = (rw > gdil_pkg::MAX_ROWS) ? gdil_pkg::MAX_ROWS : rw;
    eff_cols = (cl > gdil_pkg::MAX_COLS) ? gdil_pkg::MAX_COLS : cl;
    if (eff_rows * eff_cols > AREA_CAP) cl = $urandom_range(1, AREA_CAP / eff_rows);
  endtask

  // Every cell of the area in use must hold a loaded value before a run.
  task automatic fill_area();
    for (int r = 0; r < area_rows; r++) begin
      for (int c = 0; c < area_cols; c++) begin
        if (!loaded[r][c]) send_request(gdil_pkg::OP_LOAD, r, c, $urandom_range(0, 7) == 0);
      end
    end
  endtask

  task automatic pick_loaded(output int r, output int c);
    for (int tries = 0; tries < 32; tries++) begin
      r = $urandom_range(0, gdil_pkg::MAX_ROWS - 1);
      c = $urandom_range(0, gdil_pkg::MAX_COLS - 1);
      if (loaded[r][c]) return;
    end
    r = 0;
    c = 0;
  endtask

  task automatic mixed_traffic(input int n);
    int  k;
    int  r;
    int  c;
    int  drain_at;
    bit  has_area;
    drain_at = $urandom_range(0, n - 1);
    has_area = (area_rows > 0 && area_cols > 0);
    for (int i = 0; i < n; i++) begin
      if (i == drain_at && $urandom_range(0, 2) == 0) drain_results();
      k = $urandom_range(0, 99);
      if (k < 30 && has_area) begin
        r = $urandom_range(0, area_rows - 1);
        c = $urandom_range(0, area_cols - 1);
        send_request(gdil_pkg::OP_LOAD, r, c, $urandom_range(0, 5) == 0);
      end else if (k < 40) begin
        send_request(gdil_pkg::OP_LOAD, $urandom_range(0, gdil_pkg::MAX_ROWS - 1),
                     $urandom_range(0, gdil_pkg::MAX_COLS - 1), $urandom_range(0, 1));
      end else if (k < 88) begin
        if (k < 65 && has_area) begin
          r = $urandom_range(0, area_rows - 1);
          c = $urandom_range(0, area_cols - 1);
        end else begin
          pick_loaded(r, c);
        end
        send_request(gdil_pkg::OP_READ, r, c, $urandom_range(0, 1));
      end else if (k < 97) begin
        send_request(gdil_pkg::OP_RUN, $urandom_range(0, gdil_pkg::MAX_ROWS - 1),
                     $urandom_range(0, gdil_pkg::MAX_COLS - 1), $urandom_range(0, 1));
      end else begin
        send_request(gdil_pkg::OP_NOP, $urandom_range(0, gdil_pkg::MAX_ROWS - 1),
                     $urandom_range(0, gdil_pkg::MAX_COLS - 1), $urandom_range(0, 1));
      end
    end
  endtask

  // Result side: short random stalls, one long hold on request, none when calm.
  initial begin
    bit backlog_done;
    backlog_done = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (backlog_req && !backlog_done) begin
        backlog_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (BACKLOG_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin
    int p;
    int rw;
    int cl;
    int r;
    int c;
    in_ch.valid      <= 1'b0;
    in_ch.op         <= gdil_pkg::OP_LOAD;
    in_ch.row        <= '0;
    in_ch.col        <= '0;
    in_ch.cell_value <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= gdil_pkg::CFG_PASSES;
    cfg_ch.data      <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    settle();

    // A 3x3 area with the pass count left at its reset value of one.
    write_reg(gdil_pkg::CFG_ROWS, 3);
    write_reg(gdil_pkg::CFG_COLS, 3);
    for (int i = 0; i < 9; i++) send_request(gdil_pkg::OP_LOAD, i / 3, i % 3, 1'b0);
    send_request(gdil_pkg::OP_LOAD, gdil_pkg::MAX_ROWS - 1, gdil_pkg::MAX_COLS - 1, 1'b1);
    send_request(gdil_pkg::OP_LOAD, gdil_pkg::MAX_ROWS - 1, 0, 1'b1);
    send_request(gdil_pkg::OP_LOAD, 0, gdil_pkg::MAX_COLS - 1, 1'b1);
    send_request(gdil_pkg::OP_LOAD, 21, 42, 1'b1);
    send_request(gdil_pkg::OP_LOAD, 10, 21, 1'b0);
    send_request(gdil_pkg::OP_NOP, gdil_pkg::MAX_ROWS - 1, gdil_pkg::MAX_COLS - 1, 1'b1);
    send_request(gdil_pkg::OP_READ, gdil_pkg::MAX_ROWS - 1, gdil_pkg::MAX_COLS - 1, 1'b0);
    send_request(gdil_pkg::OP_READ, 10, 21, 1'b1);
    send_request(gdil_pkg::OP_READ, 21, 42, 1'b0);
    // The first pass only fills the border; the free center has no obstacle
    // around it yet. The second pass then grows the center.
    send_request(gdil_pkg::OP_RUN, 0, 0, 1'b0);
    send_request(gdil_pkg::OP_READ, 0, 0, 1'b0);
    send_request(gdil_pkg::OP_READ, 1, 1, 1'b0);
    send_request(gdil_pkg::OP_READ, 0, gdil_pkg::MAX_COLS - 1, 1'b0);
    send_request(gdil_pkg::OP_RUN, gdil_pkg::MAX_ROWS - 1, gdil_pkg::MAX_COLS - 1, 1'b1);
    send_request(gdil_pkg::OP_READ, 1, 1, 1'b0);

    for (int ph = 0; ph < FIXED_PHASES; ph++) begin
      configure(fixed_passes[ph], fixed_rows[ph], fixed_cols[ph]);
      fill_area();
      mixed_traffic($urandom_range(15, 30));
    end

    // Reads keep coming while the result side holds off, so the block backs up.
    backlog_req <= 1'b1;
    for (int i = 0; i < 60; i++) begin
      pick_loaded(r, c);
      send_request(gdil_pkg::OP_READ, r, c, $urandom_range(0, 1));
    end

    while (requests_sent < ITEM_TARGET) begin
      pick_config(p, rw, cl);
      configure(p, rw, cl);
      fill_area();
      mixed_traffic($urandom_range(20, 40));
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/gdil_pkg.sv
rtl/core/gdil_in_if.sv
rtl/core/gdil_out_if.sv
rtl/core/gdil_cfg_if.sv
rtl/core/grid_obstacle_dilation_unit.sv
verif/gdil_grid_checker.sv
verif/grid_obstacle_dilation_unit_tb.sv
